>>> rtl/mavg_pkg.sv
// Shared constants and types for the moving average filter.
`default_nettype none

package mavg_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SAMPLE_W   = 23;
  localparam int SIZE_W     = 5;
  localparam int POS_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + POS_W;
  localparam int STEP_W     = $clog2(SUM_W);

  localparam logic [SIZE_W-1:0] RESET_WINDOW = SIZE_W'(4);

  // Request from the control logic to the sample ring.
  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic                clear;
    logic [POS_W-1:0]    addr;
    logic [SAMPLE_W-1:0] wdata;
  } ring_req_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> rtl/mavg_ring_ram.sv
// Sample ring: synchronous memory with registered read and per-entry valid bits.
`default_nettype none

module mavg_ring_ram (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mavg_pkg::ring_req_t            req,
  output logic [mavg_pkg::SAMPLE_W-1:0]       rdata
);

  logic [mavg_pkg::SAMPLE_W-1:0] mem [mavg_pkg::MAX_WINDOW];
  logic [mavg_pkg::MAX_WINDOW-1:0] vld;
  logic [mavg_pkg::SAMPLE_W-1:0] rd_q;
  logic                          rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.addr];
    end
  end

  // An entry that was never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.addr];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/mavg_divider.sv
// Restoring serial divider: one quotient bit per cycle.
`default_nettype none

module mavg_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mavg_pkg::SUM_W-1:0]  dividend,
  input  wire logic [mavg_pkg::CNT_W-1:0]  divisor,
  output logic [mavg_pkg::SAMPLE_W-1:0]    quotient,
  output mavg_pkg::div_status_t            status
);

  logic [mavg_pkg::SUM_W-1:0]  quo;
  logic [mavg_pkg::CNT_W-1:0]  rem;
  logic [mavg_pkg::CNT_W-1:0]  dvs;
  logic [mavg_pkg::STEP_W-1:0] step;
  logic                        busy;
  logic                        done;
  logic [mavg_pkg::CNT_W:0]    rem_shift;
  logic [mavg_pkg::CNT_W:0]    rem_sub;
  logic                        fits;

  always_comb begin
    rem_shift = {rem, quo[mavg_pkg::SUM_W-1]};
    rem_sub   = rem_shift - {1'b0, dvs};
    fits      = (rem_shift >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= mavg_pkg::STEP_W'(mavg_pkg::SUM_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[mavg_pkg::SUM_W-2:0], fits};
      rem <= fits ? rem_sub[mavg_pkg::CNT_W-1:0] : rem_shift[mavg_pkg::CNT_W-1:0];
    end
  end

  // The sum never exceeds count times the largest sample, so the quotient fits.
  assign quotient    = quo[mavg_pkg::SAMPLE_W-1:0];
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

>>> rtl/moving_average_filter.sv
// Top level of the moving average filter: control, running sum and output register.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     sample (23 bits)
//   output    out        out_valid / out_stall   average (23 bits)
//   config    in         cfg_valid / cfg_ready   window_size (5 bits)
//
// Each word passes from acceptance to the output register through the ring
// read, the sum update and ring write, the serial divider (one quotient bit
// per cycle) and the output load.
// Reset brings the window size to 4 and clears the sum, count, position and
// the ring's valid bits. A new word is taken while a finished average still
// waits under out_stall; the next result waits in the divider.
`default_nettype none

module moving_average_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mavg_pkg::SAMPLE_W-1:0] sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mavg_pkg::SAMPLE_W-1:0]      average,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mavg_pkg::SIZE_W-1:0]   window_size
);

  // One-hot control states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [mavg_pkg::SIZE_W-1:0]   window;
  logic [mavg_pkg::POS_W-1:0]    pos;
  logic [mavg_pkg::CNT_W-1:0]    count;
  logic [mavg_pkg::SUM_W-1:0]    sum;
  logic [mavg_pkg::SAMPLE_W-1:0] smp;

  logic [mavg_pkg::POS_W-1:0]    pos_next;
  logic [mavg_pkg::CNT_W-1:0]    count_next;
  logic [mavg_pkg::SUM_W-1:0]    sum_next;
  logic [mavg_pkg::CNT_W-1:0]    pos_inc;

  logic                          in_accept;
  logic                          cfg_in_range;
  logic                          cfg_write;
  logic                          out_load;

  mavg_pkg::ring_req_t           ring_req;
  logic [mavg_pkg::SAMPLE_W-1:0] ring_rdata;
  mavg_pkg::div_status_t         div_status;
  logic [mavg_pkg::SAMPLE_W-1:0] quotient;

  // Configuration is taken only between words. A pending configuration word
  // holds off the input so the clear never mixes with an item in flight.
  assign cfg_ready    = (state == ST_IDLE);
  assign in_stall     = (state != ST_IDLE) || cfg_valid;
  assign in_accept    = in_valid && !in_stall;
  assign cfg_in_range = (window_size != '0) &&
                        (32'(window_size) <= 32'(mavg_pkg::MAX_WINDOW));
  assign cfg_write    = cfg_valid && cfg_ready && cfg_in_range;
  assign out_load     = (state == ST_OUT) && (!out_valid || !out_stall);

  // The ring entry at the write position holds the oldest sample; it leaves
  // the sum as the new sample enters. An unwritten entry reads as zero.
  always_comb begin
    sum_next = sum - mavg_pkg::SUM_W'(ring_rdata) + mavg_pkg::SUM_W'(smp);
    pos_inc  = mavg_pkg::CNT_W'(pos) + 1'b1;
    if (32'(pos_inc) >= 32'(window)) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[mavg_pkg::POS_W-1:0];
    end
    if (32'(count) < 32'(window)) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  // The ring is read on acceptance and written in the update state, and the next
  // read comes only after the division, so no forwarding is needed.
  always_comb begin
    ring_req.rd_en = in_accept;
    ring_req.wr_en = (state == ST_UPD);
    ring_req.clear = cfg_write;
    ring_req.addr  = pos;
    ring_req.wdata = smp;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_status.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      window    <= mavg_pkg::RESET_WINDOW;
      pos       <= '0;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        window <= window_size;
        pos    <= '0;
        count  <= '0;
        sum    <= '0;
      end else if (state == ST_UPD) begin
        pos   <= pos_next;
        count <= count_next;
        sum   <= sum_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      smp <= sample;
    end
    if (out_load) begin
      average <= quotient;
    end
  end

  mavg_ring_ram u_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  // The count is at least one after the update, so the divisor is never zero.
  mavg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_UPD),
    .dividend (sum_next),
    .divisor  (count_next),
    .quotient (quotient),
    .status   (div_status)
  );

endmodule

`default_nettype wire

>>> rtl/mavg_checker.sv
// Port-level checks for the moving average filter, bound to the top level.
`default_nettype none

module mavg_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mavg_pkg::SAMPLE_W-1:0] average,
  input wire logic                          cfg_ready
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average))
    else $error("average changed under stall");

  // One word at a time: an accepted word keeps the input stalled next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("input not held off while a word is in work");

  // A new result appears only as the block returns to idle.
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> cfg_ready)
    else $error("result appeared while still busy");

  // Whenever configuration is held off, work is under way and the input is stalled.
  a_cfg_only_idle: assert property (@(posedge clk) disable iff (rst)
    !cfg_ready |-> in_stall)
    else $error("configuration port open during work");

  // Reset leaves no result pending and the block idle.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && cfg_ready)
    else $error("state after reset not idle");

endmodule

bind moving_average_filter mavg_checker u_mavg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .average   (average),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
